### rtl/ptl_pkg.sv
// Shared constants and types for the point-to-line distance pipeline.
package ptl_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        KIND_VERTICAL   = 2'd0,
        KIND_HORIZONTAL = 2'd1,
        KIND_SLOPED     = 2'd2
    } line_kind_t;

endpackage

### rtl/ptl_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband carried alongside.
module ptl_div_pipe #(
    parameter int NUM_W  = 30,
    parameter int DEN_W  = 13,
    parameter int QUO_W  = 28,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] out_side
);

    // numerator bits above the quotient seed the remainder; caller keeps them below den
    localparam int HI_W = NUM_W - QUO_W;

    logic [QUO_W-1:0]  valid_reg;
    logic [QUO_W-1:0]  acc_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic [DEN_W-1:0]  rem_reg  [QUO_W-1];
    logic [DEN_W-1:0]  den_reg  [QUO_W-1];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_step
        logic              valid_in;
        logic [DEN_W-1:0]  rem_in;
        logic [QUO_W-1:0]  acc_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic              qbit;
        logic [DEN_W-1:0]  rem_next;
        logic [QUO_W-1:0]  acc_next;

        if (i == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:QUO_W]};
            assign acc_in   = num[QUO_W-1:0];
            assign den_in   = den;
            assign side_in  = side;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign acc_in   = acc_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign side_in  = side_reg[i-1];
        end

        always_comb
        begin
            trial = {rem_in, acc_in[QUO_W-1]};
            if (trial >= {1'b0, den_in})
            begin
                qbit     = 1'b1;
                rem_next = DEN_W'(trial - {1'b0, den_in});
            end
            else
            begin
                qbit     = 1'b0;
                rem_next = trial[DEN_W-1:0];
            end
            acc_next = {acc_in[QUO_W-2:0], qbit};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            acc_reg[i]  <= acc_next;
            side_reg[i] <= side_in;
        end

        if (i < QUO_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = acc_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

### rtl/point_to_line_distance.sv
// Point-to-line distance, fully pipelined: one transfer may start in every cycle (busy stays low).
// Each item passes the input register, the slope divider, the slope-sign, multiply and radicand
// registers, the square-root unit, the rounding register, the distance divider and the output
// register. The dividers and the square-root unit give one bit per stage; done flags each result.
// Throughput: one item per cycle; the receiver cannot stall, so nothing is ever held back.
// Reset (rst_n low, asynchronous) clears every valid bit; data registers are not reset.
module point_to_line_distance
    import ptl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [COORD_BITS-1:0]                 first_x,
    input  logic [COORD_BITS-1:0]                 first_y,
    input  logic [COORD_BITS-1:0]                 second_x,
    input  logic [COORD_BITS-1:0]                 second_y,
    input  logic [COORD_BITS-1:0]                 query_x,
    input  logic [COORD_BITS-1:0]                 query_y,
    output logic                                  done,
    output logic [1:0]                            line_kind,
    output logic signed [COORD_BITS+FRAC_BITS:0]  x_coefficient,
    output logic signed [2*COORD_BITS+FRAC_BITS:0] constant_term,
    output logic [COORD_BITS+FRAC_BITS:0]         distance
);

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int QW   = C + F;             // slope magnitude
    localparam int AW   = C + F + 1;         // signed slope
    localparam int CTW  = 2*C + F + 1;       // intercept
    localparam int PW   = AW + C + 1;        // slope times coordinate
    localparam int MW   = PW - 1;            // numerator magnitude
    localparam int RW   = C + F + 1;         // root of 1 + a*a, also distance width
    localparam int SQW  = 2 * RW;            // radicand
    localparam int N1W  = C + F + 2;         // slope dividend
    localparam int N3W  = MW + F;            // distance dividend

    typedef struct packed {
        logic [C-1:0] x1;
        logic [C-1:0] y1;
        logic [C-1:0] qx;
        logic [C-1:0] qy;
        logic         neg;
        line_kind_t   kind;
    } pts_t;

    typedef struct packed {
        line_kind_t          kind;
        logic signed [AW-1:0]  xc;
        logic signed [CTW-1:0] ct;
        logic [MW-1:0]       nmag;
        logic [C-1:0]        vmag;
    } root_sb_t;

    typedef struct packed {
        line_kind_t          kind;
        logic signed [AW-1:0]  xc;
        logic signed [CTW-1:0] ct;
        logic [C-1:0]        vmag;
    } dist_sb_t;

    // No backpressure anywhere: a transfer is taken whenever start is high.
    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic         in_vld_reg;
    logic [C-1:0] x1_reg, y1_reg, x2_reg, y2_reg, qx_reg, qy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x1_reg <= first_x;
            y1_reg <= first_y;
            x2_reg <= second_x;
            y2_reg <= second_y;
            qx_reg <= query_x;
            qy_reg <= query_y;
        end
    end

    // ---------------------------------------------------------------
    // Classify the line and form the rounded slope quotient:
    // |a| = (2*|dy|*2^F + |dx|) / (2*|dx|)
    // ---------------------------------------------------------------
    logic signed [C:0] dx_s, dy_s;
    logic [C-1:0]      mdx, mdy;
    logic [N1W-1:0]    num1;
    logic [C:0]        den1;
    pts_t              pts_in;

    always_comb
    begin
        dx_s = $signed({1'b0, x2_reg}) - $signed({1'b0, x1_reg});
        dy_s = $signed({1'b0, y2_reg}) - $signed({1'b0, y1_reg});
        mdx  = dx_s[C] ? C'(-dx_s) : dx_s[C-1:0];
        mdy  = dy_s[C] ? C'(-dy_s) : dy_s[C-1:0];
        num1 = {1'b0, mdy, {(F+1){1'b0}}} + {{(F+2){1'b0}}, mdx};
        den1 = {mdx, 1'b0};

        pts_in.x1  = x1_reg;
        pts_in.y1  = y1_reg;
        pts_in.qx  = qx_reg;
        pts_in.qy  = qy_reg;
        pts_in.neg = dx_s[C] ^ dy_s[C];
        // equal x also covers identical points
        if (x1_reg == x2_reg)
        begin
            pts_in.kind = KIND_VERTICAL;
        end
        else if (y1_reg == y2_reg)
        begin
            pts_in.kind = KIND_HORIZONTAL;  // quotient comes out zero on its own
        end
        else
        begin
            pts_in.kind = KIND_SLOPED;
        end
    end

    logic              q1_vld;
    logic [QW-1:0]     q1;
    logic [$bits(pts_t)-1:0] q1_side;

    ptl_div_pipe #(
        .NUM_W  (N1W),
        .DEN_W  (C + 1),
        .QUO_W  (QW),
        .SIDE_W ($bits(pts_t))
    ) u_slope_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_vld_reg),
        .num       (num1),
        .den       (den1),
        .side      (pts_in),
        .out_valid (q1_vld),
        .quo       (q1),
        .out_side  (q1_side)
    );

    // ---------------------------------------------------------------
    // Apply the slope sign
    // ---------------------------------------------------------------
    pts_t                 pts_q;
    logic                 a_vld_reg;
    logic signed [AW-1:0] a_reg, a_next;
    logic [QW-1:0]        am_reg;
    pts_t                 a_pts_reg;

    always_comb
    begin
        pts_q  = pts_t'(q1_side);
        a_next = pts_q.neg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= q1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        am_reg    <= q1;
        a_pts_reg <= pts_q;
    end

    // ---------------------------------------------------------------
    // Multiplies: a*x1 for the intercept, a*(qx-x1) for the numerator,
    // |a|^2 for the radicand
    // ---------------------------------------------------------------
    logic signed [C:0]     dqx, dqy;
    logic [C-1:0]          vmag_next;
    logic signed [PW-1:0]  prod_ct, ct_w, prod_n_next;
    logic signed [CTW-1:0] ct_next;
    logic signed [AW-1:0]  xc_next;
    logic [2*QW-1:0]       sq_next;

    always_comb
    begin
        dqx       = $signed({1'b0, a_pts_reg.qx}) - $signed({1'b0, a_pts_reg.x1});
        dqy       = $signed({1'b0, a_pts_reg.qy}) - $signed({1'b0, a_pts_reg.y1});
        vmag_next = dqx[C] ? C'(-dqx) : dqx[C-1:0];

        prod_ct     = a_reg * $signed({1'b0, a_pts_reg.x1});
        ct_w        = $signed({{(PW-C-F){1'b0}}, a_pts_reg.y1, {F{1'b0}}}) - prod_ct;
        prod_n_next = a_reg * dqx;
        sq_next     = am_reg * am_reg;

        if (a_pts_reg.kind == KIND_VERTICAL)
        begin
            xc_next = $signed({{(AW-F-1){1'b0}}, 1'b1, {F{1'b0}}});
            ct_next = -$signed({{(CTW-C-F){1'b0}}, a_pts_reg.x1, {F{1'b0}}});
        end
        else
        begin
            xc_next = a_reg;
            ct_next = ct_w[CTW-1:0];
        end
    end

    logic                  m_vld_reg;
    line_kind_t            m_kind_reg;
    logic signed [AW-1:0]  m_xc_reg;
    logic signed [CTW-1:0] m_ct_reg;
    logic signed [PW-1:0]  m_prod_reg;
    logic signed [C:0]     m_dqy_reg;
    logic [2*QW-1:0]       m_sq_reg;
    logic [C-1:0]          m_vmag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_kind_reg <= a_pts_reg.kind;
        m_xc_reg   <= xc_next;
        m_ct_reg   <= ct_next;
        m_prod_reg <= prod_n_next;
        m_dqy_reg  <= dqy;
        m_sq_reg   <= sq_next;
        m_vmag_reg <= vmag_next;
    end

    // ---------------------------------------------------------------
    // Numerator magnitude and radicand 2^2F + a^2
    // ---------------------------------------------------------------
    logic signed [PW-1:0] n_w, n_neg;
    logic [MW-1:0]        nmag_next;
    logic [SQW-1:0]       s_next;
    root_sb_t             p_sb_next;

    always_comb
    begin
        n_w       = $signed({m_dqy_reg, {F{1'b0}}}) - m_prod_reg;
        n_neg     = -n_w;
        nmag_next = n_w[PW-1] ? n_neg[MW-1:0] : n_w[MW-1:0];
        s_next    = SQW'(m_sq_reg) + (SQW'(1) << (2*F));

        p_sb_next.kind = m_kind_reg;
        p_sb_next.xc   = m_xc_reg;
        p_sb_next.ct   = m_ct_reg;
        p_sb_next.nmag = nmag_next;
        p_sb_next.vmag = m_vmag_reg;
    end

    logic           p_vld_reg;
    logic [SQW-1:0] p_s_reg;
    root_sb_t       p_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_s_reg  <= s_next;
        p_sb_reg <= p_sb_next;
    end

    // ---------------------------------------------------------------
    // Square root, one result bit per stage (two radicand bits each)
    // ---------------------------------------------------------------
    logic [RW-1:0]  sq_vld_reg;
    logic [RW-1:0]  root_reg [RW];
    logic [RW:0]    rem_reg  [RW];
    root_sb_t       sq_sb_reg [RW];
    logic [SQW-1:0] s_reg    [RW-1];

    for (genvar j = 0; j < RW; j++)
    begin : g_root
        logic           vld_in;
        logic [RW-1:0]  root_in;
        logic [RW:0]    rem_in;
        logic [SQW-1:0] s_in;
        root_sb_t       sb_in;
        logic [RW+2:0]  t;
        logic [RW+2:0]  trial;
        logic [RW-1:0]  root_next;
        logic [RW:0]    rem_next;

        if (j == 0)
        begin : g_first
            assign vld_in  = p_vld_reg;
            assign root_in = '0;
            assign rem_in  = '0;
            assign s_in    = p_s_reg;
            assign sb_in   = p_sb_reg;
        end
        else
        begin : g_rest
            assign vld_in  = sq_vld_reg[j-1];
            assign root_in = root_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign s_in    = s_reg[j-1];
            assign sb_in   = sq_sb_reg[j-1];
        end

        always_comb
        begin
            t     = {rem_in, s_in[SQW-1-2*j -: 2]};
            trial = {1'b0, root_in, 2'b01};
            if (t >= trial)
            begin
                rem_next  = (RW+1)'(t - trial);
                root_next = {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = t[RW:0];
                root_next = {root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[j] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[j]  <= root_next;
            rem_reg[j]   <= rem_next;
            sq_sb_reg[j] <= sb_in;
        end

        if (j < RW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                s_reg[j] <= s_in;
            end
        end
    end

    // ---------------------------------------------------------------
    // Round the root to nearest and form |N|*2^F + r/2
    // ---------------------------------------------------------------
    logic [RW-1:0]  root_f;
    logic [RW-1:0]  r_next;
    logic [N3W-1:0] num3_next;
    root_sb_t       sb_f;
    dist_sb_t       r_sb_next;

    always_comb
    begin
        root_f    = root_reg[RW-1];
        sb_f      = sq_sb_reg[RW-1];
        // remainder above the floor root means the root is past the half point
        r_next    = (rem_reg[RW-1] > {1'b0, root_f}) ? root_f + 1'b1 : root_f;
        num3_next = {sb_f.nmag, {F{1'b0}}} + N3W'(r_next >> 1);

        r_sb_next.kind = sb_f.kind;
        r_sb_next.xc   = sb_f.xc;
        r_sb_next.ct   = sb_f.ct;
        r_sb_next.vmag = sb_f.vmag;
    end

    logic           r_vld_reg;
    logic [N3W-1:0] r_num_reg;
    logic [RW-1:0]  r_den_reg;
    dist_sb_t       r_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
        end
        else
        begin
            r_vld_reg <= sq_vld_reg[RW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        r_num_reg <= num3_next;
        r_den_reg <= r_next;
        r_sb_reg  <= r_sb_next;
    end

    logic                        d_vld;
    logic [RW-1:0]               d_quo;
    logic [$bits(dist_sb_t)-1:0] d_side;

    ptl_div_pipe #(
        .NUM_W  (N3W),
        .DEN_W  (RW),
        .QUO_W  (RW),
        .SIDE_W ($bits(dist_sb_t))
    ) u_dist_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_vld_reg),
        .num       (r_num_reg),
        .den       (r_den_reg),
        .side      (r_sb_reg),
        .out_valid (d_vld),
        .quo       (d_quo),
        .out_side  (d_side)
    );

    // ---------------------------------------------------------------
    // Output register; vertical lines take |qx - x1| directly
    // ---------------------------------------------------------------
    dist_sb_t              d_sb;
    logic [RW-1:0]         dist_next;
    logic                  done_reg;
    line_kind_t            kind_out_reg;
    logic signed [AW-1:0]  xc_out_reg;
    logic signed [CTW-1:0] ct_out_reg;
    logic [RW-1:0]         dist_out_reg;

    always_comb
    begin
        d_sb = dist_sb_t'(d_side);
        if (d_sb.kind == KIND_VERTICAL)
        begin
            dist_next = {{(RW-C-F){1'b0}}, d_sb.vmag, {F{1'b0}}};
        end
        else
        begin
            dist_next = d_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_out_reg <= d_sb.kind;
        xc_out_reg   <= d_sb.xc;
        ct_out_reg   <= d_sb.ct;
        dist_out_reg <= dist_next;
    end

    assign done          = done_reg;
    assign line_kind     = kind_out_reg;
    assign x_coefficient = xc_out_reg;
    assign constant_term = ct_out_reg;
    assign distance      = dist_out_reg;

endmodule
